@@ sv/rshm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotating string hash package
// Widths, constants, the rotation lookup and the remainder unit status type.
// ----------------------------------------------------------------------------
package rshm_pkg;

	localparam int CHAR_W    = 7;
	localparam int HASH_W    = 11;
	localparam int MOD_W     = 12;
	localparam int SUM_W     = 22;
	localparam int REM_STEPS = SUM_W / 2;
	localparam int CNT_W     = $clog2(REM_STEPS + 1);
	localparam int ROT_W     = 4;
	localparam int ADDR_W    = 2;
	localparam int DATA_W    = 32;

	localparam logic [ROT_W-1:0] ROT_SPAN         = 4'd11;
	localparam logic [MOD_W-1:0] TABLE_SIZE_RESET = 12'd2039;
	localparam logic [MOD_W-1:0] MODULUS_CAP      = 12'd2048;
	localparam logic [MOD_W-1:0] MODULUS_MIN      = 12'd1;

	// Word index of the table size register.
	localparam int REG_TABLE_SIZE = 0;

	typedef struct packed {
		logic busy;
		logic last;
	} rem_status_t;

	// Character modulo 11 through a reciprocal multiply; 187/2048 gives the
	// exact quotient for every 7-bit character, and one correction step
	// guards the remainder anyway.
	function automatic logic [ROT_W-1:0] rot_amount(input logic [CHAR_W-1:0] c);
		logic [14:0] prod;
		logic [3:0]  quo;
		logic [7:0]  rem;
		prod = 15'(c) * 15'd187;
		quo  = prod[14:11];
		rem  = 8'(c) - 8'(quo) * 8'd11;
		if (rem >= 8'd11) begin
			rem = rem - 8'd11;
		end
		return rem[ROT_W-1:0];
	endfunction

endpackage

@@ sv/rshm_rem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial remainder unit
// Restoring remainder of a 22-bit sum by a 12-bit modulus, two bits a cycle.
// ----------------------------------------------------------------------------
module rshm_rem (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [rshm_pkg::SUM_W-1:0]    dividend,
	input  logic [rshm_pkg::MOD_W-1:0]    modulus,
	output rshm_pkg::rem_status_t         status,
	output logic [rshm_pkg::HASH_W-1:0]   remainder
);

	logic [rshm_pkg::SUM_W-1:0]  dvd_q;
	logic [rshm_pkg::MOD_W-1:0]  mod_q;
	logic [rshm_pkg::HASH_W-1:0] rem_q;
	logic [rshm_pkg::CNT_W-1:0]  cnt_q;

	logic [rshm_pkg::MOD_W-1:0]  try1, try2, sub1, sub2;
	logic [rshm_pkg::HASH_W-1:0] rem1;

	// Each partial remainder stays below the modulus, which is at most 2048,
	// so it fits eleven bits.
	always_comb begin
		try1 = {rem_q, dvd_q[rshm_pkg::SUM_W-1]};
		sub1 = (try1 >= mod_q) ? (try1 - mod_q) : try1;
		rem1 = sub1[rshm_pkg::HASH_W-1:0];
		try2 = {rem1, dvd_q[rshm_pkg::SUM_W-2]};
		sub2 = (try2 >= mod_q) ? (try2 - mod_q) : try2;
	end

	assign remainder   = sub2[rshm_pkg::HASH_W-1:0];
	assign status.busy = (cnt_q != '0);
	assign status.last = (cnt_q == rshm_pkg::CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= rshm_pkg::CNT_W'(rshm_pkg::REM_STEPS);
		end else if (status.busy) begin
			cnt_q <= cnt_q - rshm_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			mod_q <= modulus;
			rem_q <= '0;
		end else if (status.busy) begin
			dvd_q <= {dvd_q[rshm_pkg::SUM_W-3:0], 2'b00};
			rem_q <= remainder;
		end
	end

endmodule

@@ sv/rotating_string_hash_mod.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotating string hash with modular reduction
// Hashes a name string one character per request and emits the code at the
// terminating zero character.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (ch, ch_valid, ch_stall) carries one 7-bit character per
// request. A nonzero character rotates the running hash by the character
// modulo 11, adds the character and reduces the sum modulo the table size.
// A zero character ends the string: the running hash goes out as one request
// on the output channel (code, code_valid, code_stall) and the running hash
// is cleared, so an empty string yields code 0.
// A nonzero character holds the input channel stalled while the serial
// remainder unit, which retires two dividend bits per cycle, reduces the
// 22-bit sum; the sum is formed combinationally as the character is taken.
// The code sits in an output register; while it waits on a stalled
// receiver, further nonzero characters are still taken, and only a second
// terminator is held off until the register is free.
// The table size register sits at byte address 0 of the APB port; the user
// must write it only while the block is idle, which the block itself does
// not enforce. Zero acts as a modulus of one and values above 2048 act as
// 2048. Reset clears the running hash, empties the output register and
// loads the table size with 2039.
// ----------------------------------------------------------------------------
module rotating_string_hash_mod (
	input  logic                            clk,
	input  logic                            arst_n,
	// Character channel
	input  logic [rshm_pkg::CHAR_W-1:0]     ch,
	input  logic                            ch_valid,
	output logic                            ch_stall,
	// Code channel
	output logic [rshm_pkg::HASH_W-1:0]     code,
	output logic                            code_valid,
	input  logic                            code_stall,
	// Configuration port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [rshm_pkg::ADDR_W-1:0]     paddr,
	input  logic [rshm_pkg::DATA_W-1:0]     pwdata,
	output logic [rshm_pkg::DATA_W-1:0]     prdata,
	output logic                            pready
);

	logic [rshm_pkg::MOD_W-1:0]  table_size_q;
	logic [rshm_pkg::HASH_W-1:0] hash_q;
	logic [rshm_pkg::HASH_W-1:0] code_q;
	logic                        code_valid_q;

	logic                        accept;
	logic                        is_term;
	logic                        start;
	logic [rshm_pkg::ROT_W-1:0]  rot;
	logic [rshm_pkg::ROT_W-1:0]  rot_back;
	logic [rshm_pkg::SUM_W-1:0]  sum;
	logic [rshm_pkg::MOD_W-1:0]  eff_mod;
	logic [rshm_pkg::HASH_W-1:0] rem_result;
	rshm_pkg::rem_status_t       rem_status;

	// The register file is a single word, so every address selects it.
	logic                        reg_sel;
	logic                        cfg_write;

	assign reg_sel   = ((paddr >> 2) == rshm_pkg::ADDR_W'(rshm_pkg::REG_TABLE_SIZE));
	assign cfg_write = psel && penable && pwrite && reg_sel;
	assign pready    = 1'b1;
	assign prdata    = rshm_pkg::DATA_W'(table_size_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= rshm_pkg::TABLE_SIZE_RESET;
		end else if (cfg_write) begin
			table_size_q <= pwdata[rshm_pkg::MOD_W-1:0];
		end
	end

	// Clamp the table size into the range that keeps the hash in 11 bits.
	always_comb begin
		if (table_size_q == '0) begin
			eff_mod = rshm_pkg::MODULUS_MIN;
		end else if (table_size_q > rshm_pkg::MODULUS_CAP) begin
			eff_mod = rshm_pkg::MODULUS_CAP;
		end else begin
			eff_mod = table_size_q;
		end
	end

	// A terminator needs the output register, which frees up in the same
	// cycle when the receiver takes the pending code.
	assign is_term  = (ch == '0);
	assign ch_stall = rem_status.busy || (is_term && code_valid_q && code_stall);
	assign accept   = ch_valid && !ch_stall;
	assign start    = accept && !is_term;

	// Rotation of the running hash plus the character. With a rotation of
	// zero the right shift moves every bit out, as wanted.
	always_comb begin
		rot      = rshm_pkg::rot_amount(ch);
		rot_back = rshm_pkg::ROT_SPAN - rot;
		sum      = (rshm_pkg::SUM_W'(hash_q) << rot)
		         + rshm_pkg::SUM_W'(hash_q >> rot_back)
		         + rshm_pkg::SUM_W'(ch);
	end

	rshm_rem u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.dividend  (sum),
		.modulus   (eff_mod),
		.status    (rem_status),
		.remainder (rem_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= '0;
		end else if (rem_status.last) begin
			hash_q <= rem_result;
		end else if (accept && is_term) begin
			hash_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_valid_q <= 1'b0;
		end else if (accept && is_term) begin
			code_valid_q <= 1'b1;
		end else if (!code_stall) begin
			code_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_term) begin
			code_q <= hash_q;
		end
	end

	assign code       = code_q;
	assign code_valid = code_valid_q;

endmodule
